>>> sv/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types, constants and a ring index helper for the byte deque.
// ----------------------------------------------------------------------------
`default_nettype none

package bdq_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SUM_W   = IDX_W + 1;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 5;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [BYTE_W-1:0] t_byte;

    typedef enum logic [1:0] {
        FN_PUSH_FRONT = 2'd0,
        FN_PUSH_BACK  = 2'd1,
        FN_POP_FRONT  = 2'd2,
        FN_POP_BACK   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RD_FRONT,
        S_RD_BACK,
        S_CAP_BACK,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        RD_POP,
        RD_FRONT,
        RD_BACK
    } t_rd_sel;

    typedef struct packed {
        logic    load;
        logic    exec;
        logic    cap_pop;
        logic    cap_front;
        logic    cap_back;
        t_rd_sel rd_sel;
    } t_cmd;

    // (base + off) mod DEPTH, for off <= DEPTH
    function automatic t_idx ring_add(input t_idx base, input t_cnt off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
        end
        return IDX_W'(sum);
    endfunction

endpackage

`default_nettype wire

>>> sv/bdq_req_if.sv
// ----------------------------------------------------------------------------
// bdq_req_if
// Request channel: valid/ready with function code and push byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface bdq_req_if
    import bdq_pkg::*;
();
    logic  valid;
    logic  ready;
    t_func func;
    t_byte value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

`default_nettype wire

>>> sv/bdq_rsp_if.sv
// ----------------------------------------------------------------------------
// bdq_rsp_if
// Response channel: valid/ready with popped byte, ends, count and status.
// ----------------------------------------------------------------------------
`default_nettype none

interface bdq_rsp_if
    import bdq_pkg::*;
();
    logic               valid;
    logic               ready;
    t_byte              popped;
    t_byte              front_byte;
    t_byte              back_byte;
    logic [COUNT_W-1:0] count;
    logic               is_empty;
    t_status            status;

    modport source (output valid, output popped, output front_byte, output back_byte,
                    output count, output is_empty, output status, input ready);
    modport sink   (input valid, input popped, input front_byte, input back_byte,
                    input count, input is_empty, input status, output ready);
endinterface

`default_nettype wire

>>> sv/bdq_ctrl.sv
// ----------------------------------------------------------------------------
// bdq_ctrl
// Sequencer: accept a beat, execute, read popped/front/back bytes, present.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_ctrl
    import bdq_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_req_valid,
    input  wire  i_rsp_ready,
    output logic o_req_ready,
    output logic o_rsp_valid,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (i_req_valid) n_state = S_EXEC;
            S_EXEC:     n_state = S_RD_FRONT;
            S_RD_FRONT: n_state = S_RD_BACK;
            S_RD_BACK:  n_state = S_CAP_BACK;
            S_CAP_BACK: n_state = S_OUT;
            S_OUT:      if (i_rsp_ready) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_req_ready     = 1'b0;
        o_rsp_valid     = 1'b0;
        o_cmd           = '0;
        o_cmd.rd_sel    = RD_POP;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                o_cmd.load  = i_req_valid;
            end
            S_EXEC: begin
                o_cmd.exec   = 1'b1;
                o_cmd.rd_sel = RD_POP;
            end
            S_RD_FRONT: begin
                o_cmd.cap_pop = 1'b1;
                o_cmd.rd_sel  = RD_FRONT;
            end
            S_RD_BACK: begin
                o_cmd.cap_front = 1'b1;
                o_cmd.rd_sel    = RD_BACK;
            end
            S_CAP_BACK: begin
                o_cmd.cap_back = 1'b1;
            end
            S_OUT: begin
                o_rsp_valid = 1'b1;
            end
            default: begin
                o_req_ready = 1'b0;
            end
        endcase
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_req_ready && o_rsp_valid))
        else $error("request and response open together");

    a_load_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_cmd.exec)
        else $error("accepted beat not executed");

    a_out_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && i_rsp_ready) |=> o_req_ready)
        else $error("no return to idle after response beat");

endmodule

`default_nettype wire

>>> sv/bdq_dp.sv
// ----------------------------------------------------------------------------
// bdq_dp
// Ring store, front index, fill count and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_dp
    import bdq_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  t_cmd                i_cmd,
    input  t_func               i_func,
    input  t_byte               i_value,
    output t_byte               o_popped,
    output t_byte               o_front_byte,
    output t_byte               o_back_byte,
    output logic [COUNT_W-1:0]  o_count,
    output logic                o_is_empty,
    output t_status             o_status
);

    t_byte   r_mem [DEPTH];
    t_byte   r_rdata;
    t_idx    r_front;
    t_cnt    r_fill;
    t_func   r_func;
    t_byte   r_value;
    t_status r_status;
    t_byte   r_popped;
    t_byte   r_front_byte;
    t_byte   r_back_byte;

    t_idx    n_front;
    t_cnt    n_fill;
    t_status n_status;
    logic    wr_en;
    t_idx    wr_addr;
    t_idx    rd_addr;
    t_idx    back_addr;
    logic    full;
    logic    empty;
    logic    is_pop;

    assign full      = (r_fill == t_cnt'(DEPTH));
    assign empty     = (r_fill == '0);
    assign back_addr = ring_add(r_front, r_fill - 1'b1);
    assign is_pop    = (r_func == FN_POP_FRONT) || (r_func == FN_POP_BACK);

    always_comb begin
        n_front  = r_front;
        n_fill   = r_fill;
        n_status = ST_OK;
        wr_en    = 1'b0;
        wr_addr  = ring_add(r_front, r_fill);
        unique case (r_func)
            FN_PUSH_FRONT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_front = (r_front == '0) ? t_idx'(DEPTH - 1) : r_front - 1'b1;
                    wr_addr = n_front;
                    wr_en   = 1'b1;
                    n_fill  = r_fill + 1'b1;
                end
            end
            FN_PUSH_BACK: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    wr_en  = 1'b1;
                    n_fill = r_fill + 1'b1;
                end
            end
            FN_POP_FRONT: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_front = ring_add(r_front, t_cnt'(1));
                    n_fill  = r_fill - 1'b1;
                end
            end
            FN_POP_BACK: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_fill = r_fill - 1'b1;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_comb begin
        rd_addr = r_front;
        unique case (i_cmd.rd_sel)
            RD_POP:   rd_addr = (r_func == FN_POP_FRONT) ? r_front : back_addr;
            RD_FRONT: rd_addr = r_front;
            RD_BACK:  rd_addr = back_addr;
            default:  rd_addr = r_front;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_en) begin
            r_mem[wr_addr] <= r_value;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_fill  <= '0;
        end else if (i_cmd.exec) begin
            r_front <= n_front;
            r_fill  <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_func;
            r_value <= i_value;
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
        end
        if (i_cmd.cap_pop) begin
            r_popped <= (is_pop && r_status == ST_OK) ? r_rdata : '0;
        end
        if (i_cmd.cap_front) begin
            r_front_byte <= empty ? '0 : r_rdata;
        end
        if (i_cmd.cap_back) begin
            r_back_byte <= empty ? '0 : r_rdata;
        end
    end

    assign o_popped     = r_popped;
    assign o_front_byte = r_front_byte;
    assign o_back_byte  = r_back_byte;
    assign o_count      = COUNT_W'(r_fill);
    assign o_is_empty   = empty;
    assign o_status     = r_status;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= t_cnt'(DEPTH))
        else $error("fill count beyond depth");

    a_push_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && wr_en) |=> (r_fill == $past(r_fill) + 1'b1))
        else $error("push did not grow the queue");

    a_refused_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && n_status != ST_OK) |=> ($stable(r_fill) && $stable(r_front)))
        else $error("refused request changed the queue");

endmodule

`default_nettype wire

>>> sv/byte_deque.sv
// ----------------------------------------------------------------------------
// byte_deque
// Bounded double-ended byte queue over a ring store.
// ----------------------------------------------------------------------------
// One request is taken at a time: a request beat is answered by one response
// beat, and no new request is accepted until that response beat is taken.
// The pace is set by the single read port of the ring store, which reads the
// popped byte, then the new front byte, then the new back byte, one per cycle.
`default_nettype none

module byte_deque
    import bdq_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    bdq_req_if.sink  i_req,
    bdq_rsp_if.source o_rsp
);

    t_cmd cmd;

    bdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .o_cmd       (cmd)
    );

    bdq_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_func       (i_req.func),
        .i_value      (i_req.value),
        .o_popped     (o_rsp.popped),
        .o_front_byte (o_rsp.front_byte),
        .o_back_byte  (o_rsp.back_byte),
        .o_count      (o_rsp.count),
        .o_is_empty   (o_rsp.is_empty),
        .o_status     (o_rsp.status)
    );

endmodule

`default_nettype wire

>>> tb/byte_deque_tb.sv
// ----------------------------------------------------------------------------
// byte_deque_tb
// Self-checking bench for the ring-buffer byte deque.
// ----------------------------------------------------------------------------
// Requests come from a queue filled up front: a short directed run over the
// empty and full corners and front-index wrap, then random phases biased
// toward pushes, toward pops or neither, so the deque swings between empty and full.
// Every accepted request is applied to a local image of the ring and the
// predicted beat is queued; each response beat is compared with the oldest
// prediction. The sender runs in bursts with gaps and sometimes holds until
// all predictions are consumed; the receiver cycles through stall modes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module byte_deque_tb;
    import bdq_pkg::*;

    localparam int RANDOM_ITEMS = 750;
    localparam int IDLE_LIMIT   = 2000;
    localparam int END_CYCLES   = 20;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        t_func func;
        t_byte value;
        bit    drain_first;
    } req_item_t;

    typedef struct packed {
        t_byte              popped;
        t_byte              front_byte;
        t_byte              back_byte;
        logic [COUNT_W-1:0] count;
        logic               is_empty;
        t_status            status;
    } deque_result_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bdq_req_if req_bus ();
    bdq_rsp_if rsp_bus ();

    byte_deque u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    always #5 i_clk = ~i_clk;

    req_item_t     request_q[$];
    deque_result_t awaited_results[$];

    t_byte ring_img [DEPTH];
    t_idx  front_slot;
    t_cnt  held_bytes;

    int  fail_count = 0;
    int  idle_cycles = 0;
    bit  req_taken;
    bit  req_busy = 1'b0;
    int  burst_left = 0;
    int  gap_left = 0;
    int  rsp_cycle = 0;
    int  stall_left = 0;

    function automatic int ring_slot(int offset);
        return (int'(front_slot) + offset) % DEPTH;
    endfunction

    function automatic deque_result_t deque_apply(t_func func, t_byte value);
        deque_result_t r;
        r.popped     = '0;
        r.front_byte = '0;
        r.back_byte  = '0;
        r.status     = ST_OK;
        case (func)
            FN_PUSH_FRONT: begin
                if (int'(held_bytes) >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    front_slot = t_idx'(ring_slot(DEPTH - 1));
                    ring_img[front_slot] = value;
                    held_bytes = held_bytes + 1'b1;
                end
            end
            FN_PUSH_BACK: begin
                if (int'(held_bytes) >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    ring_img[t_idx'(ring_slot(int'(held_bytes)))] = value;
                    held_bytes = held_bytes + 1'b1;
                end
            end
            FN_POP_FRONT: begin
                if (held_bytes == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.popped = ring_img[front_slot];
                    front_slot = t_idx'(ring_slot(1));
                    held_bytes = held_bytes - 1'b1;
                end
            end
            default: begin
                if (held_bytes == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.popped = ring_img[t_idx'(ring_slot(int'(held_bytes) - 1))];
                    held_bytes = held_bytes - 1'b1;
                end
            end
        endcase
        if (held_bytes != 0) begin
            r.front_byte = ring_img[front_slot];
            r.back_byte  = ring_img[t_idx'(ring_slot(int'(held_bytes) - 1))];
        end
        r.count    = COUNT_W'(held_bytes);
        r.is_empty = (held_bytes == 0);
        return r;
    endfunction

    task automatic add_request(t_func func, t_byte value, bit drain_first);
        req_item_t it;
        it.func        = func;
        it.value       = value;
        it.drain_first = drain_first;
        request_q = {request_q, it};
    endtask

    // Accept, predict and check on the rising edge.
    always @(posedge i_clk) begin : monitor
        deque_result_t got;
        deque_result_t want;
        if (!i_rst_n) begin
            req_taken   <= 1'b0;
            idle_cycles <= 0;
            front_slot  = '0;
            held_bytes  = '0;
        end else begin
            req_taken <= req_bus.valid && req_bus.ready;
            if (req_bus.valid && req_bus.ready) begin
                awaited_results = {awaited_results,
                                   deque_apply(req_bus.func, req_bus.value)};
            end
            if (rsp_bus.valid && rsp_bus.ready) begin
                got = '{rsp_bus.popped, rsp_bus.front_byte, rsp_bus.back_byte,
                        rsp_bus.count, rsp_bus.is_empty, rsp_bus.status};
                if (awaited_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("%0t: unexpected beat popped=%02h front=%02h back=%02h",
                                 $realtime, got.popped, got.front_byte, got.back_byte);
                    end
                end else begin
                    want = awaited_results.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS) begin
                            $display("%0t: mismatch popped %02h/%02h front %02h/%02h",
                                     $realtime, want.popped, got.popped,
                                     want.front_byte, got.front_byte);
                            $display("    back %02h/%02h count %0d/%0d empty %b/%b st %0d/%0d",
                                     want.back_byte, got.back_byte, want.count, got.count,
                                     want.is_empty, got.is_empty, want.status, got.status);
                        end
                    end
                end
            end
            if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Request driver: bursts with gaps, optional hold until drained.
    always @(negedge i_clk) begin : driver
        req_item_t it;
        logic      next_valid;
        next_valid = req_bus.valid;
        if (!i_rst_n) begin
            next_valid = 1'b0;
        end else begin
            if (req_busy && req_taken) begin
                req_busy   = 1'b0;
                next_valid = 1'b0;
            end
            if (!req_busy) begin
                next_valid = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (request_q.size() != 0 &&
                             !(request_q[0].drain_first && awaited_results.size() != 0)) begin
                    it = request_q.pop_front();
                    req_bus.func  <= it.func;
                    req_bus.value <= it.value;
                    next_valid = 1'b1;
                    req_busy   = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
        req_bus.valid <= next_valid;
    end

    // Response stall pattern: cycle through four modes.
    always @(negedge i_clk) begin : receiver
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
        end else begin
            rsp_cycle++;
            case ((rsp_cycle / 150) % 4)
                0: rsp_bus.ready <= 1'b1;
                1: rsp_bus.ready <= 1'($urandom_range(0, 1));
                2: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
                default: begin
                    if (stall_left > 0) begin
                        stall_left--;
                        rsp_bus.ready <= 1'b0;
                    end else begin
                        rsp_bus.ready <= 1'b1;
                        if ($urandom_range(0, 5) == 0) begin
                            stall_left = $urandom_range(1, 12);
                        end
                    end
                end
            endcase
        end
    end

    initial begin : stimulus
        t_byte fill_vals [16] = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F, 8'hFE,
                                  8'h0F, 8'hF0, 8'h33, 8'hCC, 8'h02, 8'h40, 8'hBD, 8'h24};
        int    made;
        int    phase_len;
        int    push_pct;
        bit    is_push;
        bit    at_front;
        t_func func;

        i_rst_n = 1'b0;

        // empty pops, single-byte pops from each end, fill, refused pushes, pops when full
        add_request(FN_POP_FRONT, 8'hFF, 1'b0);
        add_request(FN_POP_BACK, 8'h00, 1'b0);
        add_request(FN_PUSH_FRONT, 8'hFF, 1'b0);
        add_request(FN_POP_BACK, 8'h00, 1'b0);
        add_request(FN_PUSH_BACK, 8'h00, 1'b0);
        add_request(FN_POP_FRONT, 8'h00, 1'b0);
        for (int i = 0; i < 16; i++) begin
            add_request(i[0] ? FN_PUSH_BACK : FN_PUSH_FRONT, fill_vals[i], 1'b0);
        end
        add_request(FN_PUSH_FRONT, 8'hA5, 1'b0);
        add_request(FN_PUSH_BACK, 8'h5A, 1'b0);
        add_request(FN_POP_FRONT, 8'h00, 1'b0);
        add_request(FN_POP_BACK, 8'h00, 1'b0);

        made = 0;
        while (made < RANDOM_ITEMS) begin
            phase_len = $urandom_range(20, 60);
            case ($urandom_range(0, 2))
                0: push_pct = 90;
                1: push_pct = 50;
                default: push_pct = 10;
            endcase
            for (int k = 0; k < phase_len && made < RANDOM_ITEMS; k++) begin
                is_push  = ($urandom_range(0, 99) < push_pct);
                at_front = 1'($urandom_range(0, 1));
                if (is_push) begin
                    func = at_front ? FN_PUSH_FRONT : FN_PUSH_BACK;
                end else begin
                    func = at_front ? FN_POP_FRONT : FN_POP_BACK;
                end
                add_request(func, t_byte'($urandom_range(0, 255)),
                            made == 0 || $urandom_range(0, 99) == 0);
                made++;
            end
        end

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (request_q.size() != 0 || req_busy) begin
            @(posedge i_clk);
        end
        while (awaited_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (END_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
